### src/dleqm_pkg.sv
`timescale 1ns / 1ps

package dleqm_pkg;

    localparam int DEPTH_DEFAULT   = 32;
    localparam int PAYLOAD_DEFAULT = 64;
    localparam int WORD_BITS       = 64;
    localparam int TAG_BITS        = 32;
    localparam int COUNT_BITS      = 32;
    localparam int CMD_BITS        = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PUSH_ATTR = 2'd0,
        CMD_PUSH_LIFE = 2'd1,
        CMD_POP       = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_READ = 2'd2
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic out_free;
    } dp_status_t;

endpackage

### src/dleqm_ram.sv
`timescale 1ns / 1ps

module dleqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/dleqm_ctrl.sv
`timescale 1ns / 1ps

module dleqm_ctrl
    import dleqm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  ctl
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        ctl.capture = 1'b0;
        ctl.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_pop) begin
                    state_next = ST_READ;
                end else if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/dleqm_dp.sv
`timescale 1ns / 1ps

module dleqm_dp
    import dleqm_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEPTH_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctrl_cmd_t             ctl,
    output dp_status_t            sts,
    input  logic [CMD_BITS-1:0]   s_cmd,
    input  logic [WORD_BITS-1:0]  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_event_valid,
    output logic                  m_from_lifecycle,
    output logic [WORD_BITS-1:0]  m_event_word,
    output logic                  m_dropped_oldest,
    output logic [COUNT_BITS-1:0] m_overflow_count
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = AW + 1;
    localparam int EW = TAG_BITS + PAYLOAD_BITS;
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);

    cmd_code_t               cmd_reg;
    logic [PAYLOAD_BITS-1:0] word_reg;

    logic [AW-1:0] attr_head_reg, attr_head_next, life_head_reg, life_head_next;
    logic [FW-1:0] attr_fill_reg, attr_fill_next, life_fill_reg, life_fill_next;
    logic [TAG_BITS-1:0]   seq_reg, seq_next;
    logic [COUNT_BITS-1:0] ovf_reg, ovf_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  ev_valid_reg, ev_valid_next;
    logic                  from_life_reg, from_life_next;
    logic [WORD_BITS-1:0]  ev_word_reg, ev_word_next;
    logic                  dropped_reg, dropped_next;

    logic          sel_life, q_full;
    logic [AW-1:0] q_head, q_tail, q_head_adv;
    logic [FW-1:0] q_fill, tail_sum, head_inc;
    logic          attr_we, life_we;
    logic [EW-1:0] wr_entry, attr_rd, life_rd;
    logic          has_a, has_l, take_life;
    logic [TAG_BITS-1:0] tag_diff;

    dleqm_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_attr_ram (
        .aclk  (aclk),
        .we    (attr_we),
        .waddr (q_tail),
        .wdata (wr_entry),
        .raddr (attr_head_reg),
        .rdata (attr_rd)
    );

    dleqm_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_life_ram (
        .aclk  (aclk),
        .we    (life_we),
        .waddr (q_tail),
        .wdata (wr_entry),
        .raddr (life_head_reg),
        .rdata (life_rd)
    );

    always_comb begin
        sel_life   = (cmd_reg == CMD_PUSH_LIFE);
        q_head     = sel_life ? life_head_reg : attr_head_reg;
        q_fill     = sel_life ? life_fill_reg : attr_fill_reg;
        q_full     = (q_fill == DEPTH_F);
        tail_sum   = {1'b0, q_head} + q_fill;
        head_inc   = {1'b0, q_head} + FW'(1);
        q_head_adv = (head_inc == DEPTH_F) ? '0 : head_inc[AW-1:0];
        if (q_full) begin
            q_tail = q_head;
        end else if (tail_sum >= DEPTH_F) begin
            q_tail = AW'(tail_sum - DEPTH_F);
        end else begin
            q_tail = tail_sum[AW-1:0];
        end
        wr_entry = {seq_reg, word_reg};
        attr_we  = ctl.commit && (cmd_reg == CMD_PUSH_ATTR);
        life_we  = ctl.commit && (cmd_reg == CMD_PUSH_LIFE);

        has_a     = (attr_fill_reg != '0);
        has_l     = (life_fill_reg != '0);
        tag_diff  = attr_rd[EW-1 -: TAG_BITS] - life_rd[EW-1 -: TAG_BITS];
        take_life = !has_a || (has_l && !tag_diff[TAG_BITS-1]);
    end

    always_comb begin
        attr_head_next = attr_head_reg;
        attr_fill_next = attr_fill_reg;
        life_head_next = life_head_reg;
        life_fill_next = life_fill_reg;
        seq_next       = seq_reg;
        ovf_next       = ovf_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        ev_valid_next  = ev_valid_reg;
        from_life_next = from_life_reg;
        ev_word_next   = ev_word_reg;
        dropped_next   = dropped_reg;
        if (ctl.commit) begin
            m_valid_next   = 1'b1;
            ev_valid_next  = 1'b0;
            from_life_next = 1'b0;
            ev_word_next   = '0;
            dropped_next   = 1'b0;
            case (cmd_reg)
                CMD_PUSH_ATTR, CMD_PUSH_LIFE: begin
                    seq_next     = seq_reg + TAG_BITS'(1);
                    dropped_next = q_full;
                    if (sel_life) begin
                        if (q_full) begin
                            life_head_next = q_head_adv;
                        end else begin
                            life_fill_next = life_fill_reg + FW'(1);
                        end
                    end else begin
                        if (q_full) begin
                            attr_head_next = q_head_adv;
                            ovf_next       = ovf_reg + COUNT_BITS'(1);
                        end else begin
                            attr_fill_next = attr_fill_reg + FW'(1);
                        end
                    end
                end
                CMD_POP: begin
                    if (has_a || has_l) begin
                        ev_valid_next  = 1'b1;
                        from_life_next = take_life;
                        if (take_life) begin
                            ev_word_next   = WORD_BITS'(life_rd[PAYLOAD_BITS-1:0]);
                            life_fill_next = life_fill_reg - FW'(1);
                            life_head_next = (life_head_reg == AW'(QUEUE_DEPTH - 1)) ?
                                             '0 : life_head_reg + AW'(1);
                        end else begin
                            ev_word_next   = WORD_BITS'(attr_rd[PAYLOAD_BITS-1:0]);
                            attr_fill_next = attr_fill_reg - FW'(1);
                            attr_head_next = (attr_head_reg == AW'(QUEUE_DEPTH - 1)) ?
                                             '0 : attr_head_reg + AW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg  <= cmd_code_t'(s_cmd);
            word_reg <= s_payload[PAYLOAD_BITS-1:0];
        end
        ev_valid_reg  <= ev_valid_next;
        from_life_reg <= from_life_next;
        ev_word_reg   <= ev_word_next;
        dropped_reg   <= dropped_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_head_reg <= '0;
            attr_fill_reg <= '0;
            life_head_reg <= '0;
            life_fill_reg <= '0;
            seq_reg       <= '0;
            ovf_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            attr_head_reg <= attr_head_next;
            attr_fill_reg <= attr_fill_next;
            life_head_reg <= life_head_next;
            life_fill_reg <= life_fill_next;
            seq_reg       <= seq_next;
            ovf_reg       <= ovf_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign sts.is_pop       = (cmd_reg == CMD_POP);
    assign sts.out_free     = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_event_valid    = ev_valid_reg;
    assign m_from_lifecycle = from_life_reg;
    assign m_event_word     = ev_word_reg;
    assign m_dropped_oldest = dropped_reg;
    assign m_overflow_count = ovf_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        attr_fill_reg <= DEPTH_F && life_fill_reg <= DEPTH_F)
        else $error("queue fill exceeds depth");

    a_ovf_only_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(ovf_reg) |-> $past(ctl.commit) && $past(cmd_reg) == CMD_PUSH_ATTR)
        else $error("overflow count moved without an attribute push");

    a_seq_only_on_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(seq_reg) |-> $past(ctl.commit) &&
            ($past(cmd_reg) == CMD_PUSH_ATTR || $past(cmd_reg) == CMD_PUSH_LIFE))
        else $error("sequence counter moved without a push");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.commit |=> m_valid_reg)
        else $error("committed item produced no result");

endmodule

### src/dual_lossy_event_queue_merge.sv
`timescale 1ns / 1ps
// Channel  | Ports                                              | Direction
// input    | s_valid s_ready s_cmd s_payload                     | in
// result   | m_valid m_ready m_event_valid m_from_lifecycle      | out
//          | m_event_word m_dropped_oldest m_overflow_count      |
// Push and no-op items go from accept through the EXEC state back to idle for the next
// accept; pops also pass through READ, for the registered read of both queue heads from
// the entry RAMs. The result is registered at commit and is then valid on m_valid.
// One item is in work at a time; the next is accepted while its result waits.
// aresetn is synchronous; queues empty and counters cleared, no RAM sweep.
// A stalled result holds the finishing item until m_ready.

module dual_lossy_event_queue_merge
    import dleqm_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEPTH_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_BITS-1:0]   s_cmd,
    input  logic [WORD_BITS-1:0]  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_event_valid,
    output logic                  m_from_lifecycle,
    output logic [WORD_BITS-1:0]  m_event_word,
    output logic                  m_dropped_oldest,
    output logic [COUNT_BITS-1:0] m_overflow_count
);

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    dleqm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    dleqm_dp #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .sts              (sts),
        .s_cmd            (s_cmd),
        .s_payload        (s_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_valid    (m_event_valid),
        .m_from_lifecycle (m_from_lifecycle),
        .m_event_word     (m_event_word),
        .m_dropped_oldest (m_dropped_oldest),
        .m_overflow_count (m_overflow_count)
    );

endmodule
